// ===== rtl/core/kbd_pkg.sv =====
// Shared types and constants for the keyboard scan-code port.
// Used by kbd_ring and keyboard_scancode_fifo_port_unit; no dependencies.
`default_nettype none

package kbd_pkg;

  // Default ring depth in bytes; the ring holds at most depth - 1 bytes
  localparam int unsigned RING_DEPTH_DEF = 32;

  // Request kinds
  typedef enum logic [1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActKey   = 2'd2,
    ActNop   = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    FaultNone   = 2'd0,
    FaultOffset = 2'd1,
    FaultIsrBit = 2'd2
  } fault_e;

  // Register byte offsets
  localparam logic [2:0] OffCsr = 3'd0;
  localparam logic [2:0] OffIsr = 3'd4;

  // Register bit masks
  localparam logic [15:0] RdrfBit   = 16'h0001;
  localparam logic [15:0] ClkEnBit  = 16'h8000;
  localparam logic [15:0] CsrRoMask = 16'h07FF;
  localparam logic [15:0] CsrRwMask = 16'hF800;

  // Scan-code prefixes
  localparam logic [7:0] PrefixExt = 8'hE0;
  localparam logic [7:0] PrefixUp  = 8'hF0;

  // Ring update for one request
  typedef struct packed {
    logic            en;          // request is being processed
    logic [1:0]      push_cnt;    // bytes to push, 0 to 3
    logic [2:0][7:0] push_bytes;  // byte 0 is pushed first
    logic            pop;         // take the head after the pushes
  } ring_ctrl_t;

  // Ring view after this request's pushes
  typedef struct packed {
    logic       avail;  // at least one byte held
    logic [7:0] head;   // oldest byte
  } ring_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/kbd_ring.sv =====
// Byte ring of the keyboard port: up to three pushes and one pop per request.
// Oldest byte is dropped on overflow. Depends on kbd_pkg.
`default_nettype none

module kbd_ring #(
  parameter int unsigned RING_DEPTH = kbd_pkg::RING_DEPTH_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  kbd_pkg::ring_ctrl_t     ctrl_i,
  output kbd_pkg::ring_stat_t     stat_o
);
  import kbd_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);

  // Advance a pointer with wrap at the ring depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  logic [7:0]    ring_q [RING_DEPTH];
  logic [7:0]    ring_d [RING_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] nxt;
  logic [PW-1:0] rd_mid;

  // Apply pushes in order, then look at and optionally take the head
  always_comb begin
    ring_d   = ring_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    nxt      = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < ctrl_i.push_cnt) begin
        ring_d[wr_ptr_d] = ctrl_i.push_bytes[k];
        nxt = ptr_inc(wr_ptr_d);
        if (nxt == rd_ptr_d) begin
          rd_ptr_d = ptr_inc(rd_ptr_d);
        end
        wr_ptr_d = nxt;
      end
    end
    rd_mid       = rd_ptr_d;
    stat_o.avail = (wr_ptr_d != rd_mid);
    stat_o.head  = ring_d[rd_mid];
    if (ctrl_i.pop && stat_o.avail) begin
      rd_ptr_d = ptr_inc(rd_mid);
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else if (ctrl_i.en) begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Byte storage, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      ring_q <= ring_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/keyboard_scancode_fifo_port_unit.sv =====
// Keyboard scan-code port: CSR/ISR bus registers in front of a byte ring.
// Depends on kbd_pkg and kbd_ring.
//
// Usage:
//   One input channel carries requests: a bus read, a bus write (offset 0
//   CSR, offset 4 ISR) or a key event with a mapped set-2 code. One output
//   channel returns one result per request: read data, interrupt raise and
//   lower strobes, and a fault code. Both channels use valid/stall; a
//   request moves at an edge where valid is high and stall is low.
//   The request lands in the input register first; the register and ring
//   update then happens together with the loading of the result register.
//   Throughput is one request per cycle while the receiver does not stall;
//   the single ring pass (up to three pushes and one pop) sets that figure.
//   Reset clears CSR, the receive-full flag and both ring pointers; ring
//   contents are not cleared. When the receiver stalls a valid result, the
//   result register holds, the input register holds behind it and
//   in_stall_o rises; an empty result register still takes the request
//   already waiting.
`default_nettype none

module keyboard_scancode_fifo_port_unit #(
  parameter int unsigned RING_DEPTH = kbd_pkg::RING_DEPTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  // request channel
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [1:0]  action_i,
  input  wire [2:0]  offset_i,
  input  wire [15:0] write_data_i,
  input  wire [7:0]  scan_code_i,
  input  wire        extended_i,
  input  wire        key_up_i,
  // result channel
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [15:0] read_data_o,
  output logic       irq_raise_o,
  output logic       irq_lower_o,
  output logic [1:0] fault_o
);
  import kbd_pkg::*;

  // Input register
  logic        in_valid_q;
  action_e     action_q;
  logic [2:0]  offset_q;
  logic [15:0] wdata_q;
  logic [7:0]  code_q;
  logic        ext_q;
  logic        up_q;

  // Result register
  logic        out_valid_q;
  logic [15:0] rdata_q, rdata_d;
  logic        raise_q, raise_d;
  logic        lower_q, lower_d;
  fault_e      fault_q, fault_d;

  // Block state
  logic [15:0] csr_q, csr_d;
  logic        rf_q, rf_d;

  logic        adv;
  logic        fire;
  ring_ctrl_t  ring_ctrl;
  ring_stat_t  ring_stat;

  // Handshake: the result register frees when empty or taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  // Hold or load the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q <= action_e'(action_i);
      offset_q <= offset_i;
      wdata_q  <= write_data_i;
      code_q   <= scan_code_i;
      ext_q    <= extended_i;
      up_q     <= key_up_i;
    end
  end

  // Decode the request and compute the next register state
  always_comb begin
    csr_d     = csr_q;
    rf_d      = rf_q;
    rdata_d   = '0;
    raise_d   = 1'b0;
    lower_d   = 1'b0;
    fault_d   = FaultNone;
    ring_ctrl = '0;
    ring_ctrl.en = fire;

    unique case (action_q)
      ActRead: begin
        if (offset_q == OffCsr) begin
          rdata_d = csr_q;
        end else if (offset_q == OffIsr) begin
          rdata_d = rf_q ? RdrfBit : 16'h0000;
        end else begin
          fault_d = FaultOffset;
        end
      end
      ActWrite: begin
        if (offset_q == OffCsr) begin
          csr_d = (csr_q & CsrRoMask) | (wdata_q & CsrRwMask);
        end else if (offset_q == OffIsr) begin
          if ((wdata_q & ~RdrfBit) != 16'h0000) begin
            fault_d = FaultIsrBit;
          end else if ((wdata_q & RdrfBit) != 16'h0000 && rf_q) begin
            // acknowledge, then deliver the next byte if any
            lower_d       = 1'b1;
            rf_d          = 1'b0;
            ring_ctrl.pop = 1'b1;
            if (ring_stat.avail) begin
              raise_d = 1'b1;
              rf_d    = 1'b1;
              csr_d   = (csr_q & CsrRwMask) | {8'h00, ring_stat.head};
            end
          end
        end else begin
          fault_d = FaultOffset;
        end
      end
      ActKey: begin
        if ((csr_q & ClkEnBit) != 16'h0000) begin
          // push prefixes then the code
          priority if (ext_q && up_q) begin
            ring_ctrl.push_cnt   = 2'd3;
            ring_ctrl.push_bytes = {code_q, PrefixUp, PrefixExt};
          end else if (ext_q) begin
            ring_ctrl.push_cnt   = 2'd2;
            ring_ctrl.push_bytes = {8'h00, code_q, PrefixExt};
          end else if (up_q) begin
            ring_ctrl.push_cnt   = 2'd2;
            ring_ctrl.push_bytes = {8'h00, code_q, PrefixUp};
          end else begin
            ring_ctrl.push_cnt   = 2'd1;
            ring_ctrl.push_bytes = {8'h00, 8'h00, code_q};
          end
          // deliver when the receive register is free
          if (!rf_q) begin
            ring_ctrl.pop = 1'b1;
            if (ring_stat.avail) begin
              raise_d = 1'b1;
              rf_d    = 1'b1;
              csr_d   = (csr_q & CsrRwMask) | {8'h00, ring_stat.head};
            end
          end
        end
      end
      ActNop: begin
      end
      default: begin
      end
    endcase
  end

  kbd_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ring_ctrl),
    .stat_o (ring_stat)
  );

  // Advance registers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csr_q       <= '0;
      rf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        csr_q <= csr_d;
        rf_q  <= rf_d;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q <= rdata_d;
      raise_q <= raise_d;
      lower_q <= lower_d;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign irq_raise_o = raise_q;
  assign irq_lower_o = lower_q;
  assign fault_o     = fault_q;

endmodule

`default_nettype wire
